// File: rtl/mas_pkg.sv
// Shared types and constants for the modular add/sub/mul core.
// Used by mas_cell, modular_add_sub_mul_core and the testbench; depends on nothing else.
`default_nettype none
package mas_pkg;

    // Action codes
    localparam logic [1:0] ACT_ADD  = 2'd0;
    localparam logic [1:0] ACT_SUB  = 2'd1;
    localparam logic [1:0] ACT_MUL  = 2'd2;
    localparam logic [1:0] ACT_NONE = 2'd3;

    // Operand width and width of the dividend fed to the reduction chain
    localparam int OPW   = 31;
    localparam int NUM_W = 63;

    // One request as it travels down the reduction chain
    typedef struct packed {
        logic             vld;
        logic [OPW-1:0]   rem;
        logic [NUM_W-1:0] num;
        logic [OPW-1:0]   modv;
        logic             byp;
        logic [31:0]      bval;
    } link_t;

endpackage
`default_nettype wire

// File: rtl/modular_add_sub_mul_core.sv
// Top level of the modular add/sub/mul core: operand stages, reduction chain,
// output register. Depends on mas_pkg and mas_cell.
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  config   | modulus_we, modulus_data                  | in
//  request  | in_valid/in_ready, action, operand_a/_b   | in
//  result   | out_valid/out_ready, result               | out
//
// One request per cycle while the output is not stalled; the pipe is the multiply
// and dividend-forming stages, then a chain of 63 reduction cells (one dividend
// bit per cell), then the output register. Reset clears all valid flags and the modulus.
// A stalled output freezes the whole pipe; in_ready follows that stall.
`default_nettype none
module modular_add_sub_mul_core #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        modulus_we,
    input  wire logic [30:0] modulus_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  action,
    input  wire logic [30:0] operand_a,
    input  wire logic [30:0] operand_b,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic signed [31:0] result
);

    localparam int OPW   = mas_pkg::OPW;
    localparam int NUM_W = mas_pkg::NUM_W;

    logic [OPW-1:0]     modulus_reg;
    logic               adv;
    logic               s1_vld_reg;
    logic [1:0]         s1_act_reg;
    logic [OPW-1:0]     s1_a_reg;
    logic [OPW-1:0]     s1_b_reg;
    logic [OPW-1:0]     s1_m_reg;
    logic [2*OPW-1:0]   s1_prod_reg;
    logic               s2_vld_reg;
    mas_pkg::link_t     s2_reg;
    mas_pkg::link_t     s2_next;
    mas_pkg::link_t     s2_link;
    logic [31:0]        raw;
    logic [31:0]        wrapped;
    mas_pkg::link_t     links [0:NUM_W];
    logic               out_vld_reg;
    logic [31:0]        res_reg;
    logic [31:0]        res_next;

    assign adv       = !out_vld_reg || out_ready;
    assign in_ready  = adv;
    assign out_valid = out_vld_reg;
    assign result    = res_reg;

    // Hold the modulus register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            modulus_reg <= '0;
        else if (modulus_we)
            modulus_reg <= modulus_data;
    end

    // Stage one: capture operands and form the product
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else if (adv)
            s1_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_act_reg  <= action;
            s1_a_reg    <= operand_a;
            s1_b_reg    <= operand_b;
            s1_m_reg    <= modulus_reg;
            s1_prod_reg <= (2*OPW)'(operand_a) * (2*OPW)'(operand_b);
        end
    end

    // Stage two: build the non-negative dividend and the wrapped bypass value
    always_comb
    begin
        case (s1_act_reg)
            mas_pkg::ACT_ADD: raw = {1'b0, s1_a_reg} + {1'b0, s1_b_reg};
            mas_pkg::ACT_SUB: raw = {1'b0, s1_a_reg} - {1'b0, s1_b_reg};
            mas_pkg::ACT_MUL: raw = s1_prod_reg[31:0];
            default:          raw = '0;
        endcase
        for (int i = 0; i < 32; i++)
            wrapped[i] = (i < DATA_WIDTH) ? raw[i] : raw[DATA_WIDTH-1];

        s2_next      = '0;
        s2_next.vld  = s1_vld_reg;
        s2_next.modv = s1_m_reg;
        s2_next.byp  = (s1_m_reg == '0) || (s1_act_reg == mas_pkg::ACT_NONE);
        s2_next.bval = (s1_act_reg == mas_pkg::ACT_NONE) ? 32'd0 : wrapped;
        case (s1_act_reg)
            mas_pkg::ACT_ADD:
                s2_next.num = {32'd0, s1_a_reg} + {32'd0, s1_b_reg};
            // a - b + m * 2^31 stays non-negative and keeps the same residue
            mas_pkg::ACT_SUB:
                s2_next.num = {1'b0, s1_m_reg, 31'd0} + {32'd0, s1_a_reg}
                            - {32'd0, s1_b_reg};
            mas_pkg::ACT_MUL:
                s2_next.num = {1'b0, s1_prod_reg};
            default:
                s2_next.num = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vld_reg <= 1'b0;
        else if (adv)
            s2_vld_reg <= s2_next.vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            s2_reg <= s2_next;
    end

    always_comb
    begin
        s2_link     = s2_reg;
        s2_link.vld = s2_vld_reg;
    end

    assign links[0] = s2_link;

    // Reduction chain, one dividend bit per cell
    for (genvar g = 0; g < NUM_W; g++)
    begin : g_cell
        mas_cell u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .en   (adv),
            .lin  (links[g]),
            .lout (links[g+1])
        );
    end

    // Output register
    assign res_next = links[NUM_W].byp ? links[NUM_W].bval
                                       : {1'b0, links[NUM_W].rem};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv)
            out_vld_reg <= links[NUM_W].vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            res_reg <= res_next;
    end

endmodule
`default_nettype wire

// File: rtl/mas_cell.sv
// One restoring-reduction cell: shifts one dividend bit into the remainder.
// Depends on mas_pkg.
`default_nettype none
module mas_cell (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire mas_pkg::link_t lin,
    output mas_pkg::link_t      lout
);

    logic [mas_pkg::OPW:0]   r2;
    logic [mas_pkg::OPW:0]   diff;
    logic [mas_pkg::OPW-1:0] rem_next;
    logic                    vld_reg;
    mas_pkg::link_t          pay_reg;
    mas_pkg::link_t          pay_next;

    // Shift in the next dividend bit and subtract the modulus when it fits
    always_comb
    begin
        r2       = {lin.rem, lin.num[mas_pkg::NUM_W-1]};
        diff     = r2 - {1'b0, lin.modv};
        rem_next = (r2 >= {1'b0, lin.modv}) ? diff[mas_pkg::OPW-1:0]
                                             : r2[mas_pkg::OPW-1:0];
        pay_next     = lin;
        pay_next.rem = rem_next;
        pay_next.num = {lin.num[mas_pkg::NUM_W-2:0], 1'b0};
    end

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= lin.vld;
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        if (en)
            pay_reg <= pay_next;
    end

    always_comb
    begin
        lout     = pay_reg;
        lout.vld = vld_reg;
    end

endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for modular_add_sub_mul_core: random and directed
// add/sub/mul/none requests under several modulus settings. Depends on mas_pkg and the core.
module testbench;

    localparam int DW       = 32;
    localparam int LATENCY  = 70;
    localparam string PASS_MSG = "** modular_add_sub_mul_core: PASSED **";
    localparam string FAIL_MSG = "** modular_add_sub_mul_core: FAILED **";

    typedef struct packed {
        logic [1:0]  act;
        logic [30:0] a;
        logic [30:0] b;
    } request_t;

    logic        clk;
    logic        rst_n;
    logic        modulus_we;
    logic [30:0] modulus_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  action;
    logic [30:0] operand_a;
    logic [30:0] operand_b;
    logic        out_valid;
    logic        out_ready;
    logic signed [31:0] result;

    request_t    pending_q[$];
    logic [31:0] expected_q[$];
    logic [30:0] cur_modulus;
    int          mismatches;
    int          long_stall;
    bit          hold_sender;
    int          burst_left;
    int          gap_left;
    int          stall_phase;

    modular_add_sub_mul_core #(.DATA_WIDTH(DW)) dut (
        .clk(clk), .rst_n(rst_n),
        .modulus_we(modulus_we), .modulus_data(modulus_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .action(action), .operand_a(operand_a), .operand_b(operand_b),
        .out_valid(out_valid), .out_ready(out_ready), .result(result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Compute the expected result of one request under the given modulus
    function automatic logic [31:0] modular_result(request_t r, logic [30:0] m);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] br;
        logic [63:0] v;
        logic [63:0] wmask;
        a = {33'd0, r.a};
        b = {33'd0, r.b};
        v = 64'd0;
        if (r.act == mas_pkg::ACT_NONE)
            return 32'd0;
        if (m != 0)
        begin
            a = a % m;
            if (r.act == mas_pkg::ACT_ADD)
                v = (a + b) % m;
            else if (r.act == mas_pkg::ACT_SUB)
            begin
                br = b % m;
                v = (a >= br) ? a - br : a + m - br;
            end
            else
                v = (a * b) % m;
            return v[31:0];
        end
        if (r.act == mas_pkg::ACT_ADD)
            v = a + b;
        else if (r.act == mas_pkg::ACT_SUB)
            v = a - b;
        else
            v = a * b;
        wmask = (64'd1 << DW) - 64'd1;
        v = v & wmask;
        if (v[DW-1])
            v = v | ~wmask;
        return v[31:0];
    endfunction

    function automatic logic [30:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return 31'd0;
            1: return 31'h7FFF_FFFF;
            2: return 31'($urandom_range(0, 15));
            3: return 31'h7FFF_FFFF - 31'($urandom_range(0, 15));
            default: return 31'($urandom);
        endcase
    endfunction

    // Driver: issue queued requests in bursts with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            action     <= mas_pkg::ACT_ADD;
            operand_a  <= '0;
            operand_b  <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_q.push_back(modular_result(
                    request_t'({action, operand_a, operand_b}), cur_modulus));
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_q.size() != 0 && !hold_sender)
                begin
                    request_t r;
                    r = pending_q.pop_front();
                    in_valid  <= 1'b1;
                    action    <= r.act;
                    operand_a <= r.a;
                    operand_b <= r.b;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0
                                      : $urandom_range(1, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern, plus long hold-offs counted here
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready   <= 1'b0;
            stall_phase <= 0;
        end
        else if (long_stall > 0)
        begin
            long_stall <= long_stall - 1;
            out_ready  <= 1'b0;
        end
        else
        begin
            stall_phase <= (stall_phase + 1) % 300;
            if (stall_phase < 100)
                out_ready <= 1'b1;
            else if (stall_phase < 200)
                out_ready <= ($urandom_range(0, 3) != 0);
            else
                out_ready <= ($urandom_range(0, 1) != 0);
        end
    end

    // Monitor: compare each result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %0d", result);
            end
            else
            begin
                logic [31:0] exp_v;
                exp_v = expected_q.pop_front();
                if (result !== exp_v)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %0d got %0d",
                                 $signed(exp_v), result);
                end
            end
        end
    end

    task automatic push_req(logic [1:0] act, logic [30:0] a, logic [30:0] b);
        request_t r;
        r.act = act;
        r.a   = a;
        r.b   = b;
        pending_q.push_back(r);
    endtask

    task automatic drain();
        while (pending_q.size() != 0 || in_valid || expected_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic set_modulus(logic [30:0] m);
        @(posedge clk);
        modulus_we   <= 1'b1;
        modulus_data <= m;
        cur_modulus  <= m;
        @(posedge clk);
        modulus_we   <= 1'b0;
    endtask

    task automatic random_phase(int n);
        logic [1:0] act;
        for (int i = 0; i < n; i++)
        begin
            act = ($urandom_range(0, 19) == 0) ? mas_pkg::ACT_NONE
                  : 2'($urandom_range(0, 2));
            push_req(act, rand_operand(), rand_operand());
        end
    endtask

    initial
    begin
        logic [30:0] moduli[6];
        rst_n        = 1'b0;
        modulus_we   = 1'b0;
        modulus_data = '0;
        cur_modulus  = '0;
        mismatches   = 0;
        long_stall   = 0;
        hold_sender  = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, every action, wrapping with modulus zero
        for (int act = 0; act < 4; act++)
        begin
            push_req(2'(act), 31'd0, 31'd0);
            push_req(2'(act), 31'h7FFF_FFFF, 31'h7FFF_FFFF);
            push_req(2'(act), 31'd0, 31'h7FFF_FFFF);
            push_req(2'(act), 31'h7FFF_FFFF, 31'd1);
        end
        push_req(mas_pkg::ACT_SUB, 31'd3, 31'd5);
        push_req(mas_pkg::ACT_MUL, 31'h1_0000, 31'h1_0000);
        drain();

        // Directed under a small modulus: subtract with underflow, max-operand mul and add
        set_modulus(31'd7);
        push_req(mas_pkg::ACT_SUB, 31'd2, 31'd5);
        push_req(mas_pkg::ACT_SUB, 31'h7FFF_FFFF, 31'd0);
        push_req(mas_pkg::ACT_MUL, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        push_req(mas_pkg::ACT_ADD, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        random_phase(200);
        // Hold the receiver off long enough to back up the pipe
        long_stall = 400;
        drain();

        moduli = '{31'd1, 31'h7FFF_FFFF, 31'($urandom), 31'd2, 31'd65521, 31'd0};
        foreach (moduli[i])
        begin
            set_modulus(moduli[i]);
            random_phase(250);
            if (i == 2)
            begin
                // Pause the sender until all results are in, then resume
                wait (pending_q.size() < 100);
                hold_sender = 1'b1;
                while (in_valid || expected_q.size() != 0)
                    @(posedge clk);
                hold_sender = 1'b0;
            end
            drain();
        end

        if (mismatches == 0)
            $display(PASS_MSG);
        else
            $display(FAIL_MSG);
        $finish;
    end

    initial
    begin
        #2000000;
        $display(FAIL_MSG);
        $finish;
    end
endmodule

// File: sim.f
rtl/mas_pkg.sv
rtl/mas_cell.sv
rtl/modular_add_sub_mul_core.sv
tb/sv/testbench.sv
